### src/scw_pkg.sv
// ----------------------------------------------------------------------------
// scw_pkg: shared definitions for the shortest coprime window block
// Holds default sizes, result field widths and the sequencer state type.
// ----------------------------------------------------------------------------
`default_nettype none

package scw_pkg;

  // Default sizes of the window and of one value.
  localparam int MAX_WINDOW_DEF = 1024;
  localparam int VALUE_BITS_DEF = 63;

  // Result field widths.
  localparam int BEST_W      = 11;
  localparam int OUT_TDATA_W = 16;
  localparam int OUT_TUSER_W = 2;

  // Sequencer states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_PUSH,
    S_CHK,
    S_FRD,
    S_FWT,
    S_XRD,
    S_XWT,
    S_XG,
    S_OUT
  } scw_state_t;

endpackage

`default_nettype wire

### src/scw_gcd.sv
// ----------------------------------------------------------------------------
// scw_gcd: iterative binary GCD unit
// Computes GCD(a, b) with one shift or one subtract per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module scw_gcd #(
  parameter int W = 63
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         start,
  input  wire logic [W-1:0] a_in,
  input  wire logic [W-1:0] b_in,
  output logic              busy,
  output logic              done,
  output logic [W-1:0]      result
);
  localparam int KW = $clog2(W + 1);

  logic [W-1:0]  a_r, a_nxt, b_r, b_nxt, res_r, res_nxt;
  logic [KW-1:0] k_r, k_nxt;
  logic          busy_r, busy_nxt, done_r, done_nxt;

  // Operand and control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    k_r   <= k_nxt;
    res_r <= res_nxt;
  end

  // One reduction step per cycle: common factors of two are counted in k,
  // single factors of two are dropped, and two odd operands are subtracted.
  always_comb begin
    a_nxt    = a_r;
    b_nxt    = b_r;
    k_nxt    = k_r;
    res_nxt  = res_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      a_nxt    = a_in;
      b_nxt    = b_in;
      k_nxt    = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (a_r == '0) begin
        res_nxt  = b_r << k_r;
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else if (b_r == '0) begin
        res_nxt  = a_r << k_r;
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else if (!a_r[0] && !b_r[0]) begin
        a_nxt = a_r >> 1;
        b_nxt = b_r >> 1;
        k_nxt = k_r + KW'(1);
      end else if (!a_r[0]) begin
        a_nxt = a_r >> 1;
      end else if (!b_r[0]) begin
        b_nxt = b_r >> 1;
      end else if (a_r >= b_r) begin
        a_nxt = a_r - b_r;
      end else begin
        b_nxt = b_r - a_r;
      end
    end
  end

  assign busy   = busy_r;
  assign done   = done_r;
  assign result = res_r;

  // A new operation is only started while the unit is free.
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r)
    else $error("gcd started while busy");

  // Completion ends the busy period.
  a_done_free: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r)
    else $error("gcd done while still busy");

  // A busy unit either finishes or stays busy.
  a_busy_cont: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && !start) |=> (busy_r || done_r))
    else $error("gcd lost its operation");

endmodule

`default_nettype wire

### src/scw_ram.sv
// ----------------------------------------------------------------------------
// scw_ram: single write, single read memory with registered read data
// Holds one stack of the window.
// ----------------------------------------------------------------------------
`default_nettype none

module scw_ram #(
  parameter int DEPTH = 1024,
  parameter int W     = 63
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [W-1:0]             wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic [W-1:0]                  rdata
);
  logic [W-1:0] mem [DEPTH];
  logic [W-1:0] rdata_r;

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

### src/shortest_coprime_window.sv
// ----------------------------------------------------------------------------
// shortest_coprime_window: shortest window of a stream whose GCD is one
// Two-stack sliding window queue with running GCD prefixes.
// ----------------------------------------------------------------------------
// One item is taken at a time. Each GCD runs on a shared binary GCD unit
// that does one shift or subtract per cycle. An item costs a push GCD and
// a check GCD, plus a memory read and one more check GCD per pop; when the
// front stack empties, the back stack is moved over with one GCD and one
// memory read per moved value. A refused item starts no GCD; the amortized
// cost is at most about four GCDs per item. The result item is held
// until taken; no new item is accepted until then.
`default_nettype none

module shortest_coprime_window #(
  parameter int MAX_WINDOW = scw_pkg::MAX_WINDOW_DEF,
  parameter int VALUE_BITS = scw_pkg::VALUE_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  input  wire logic [8*((VALUE_BITS+7)/8)-1:0] in_tdata,  // value
  input  wire logic                            in_tlast,  // last
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  output logic [scw_pkg::OUT_TDATA_W-1:0]      out_tdata, // best_length
  output logic [scw_pkg::OUT_TUSER_W-1:0]      out_tuser, // found, overflow
  output logic                                 out_tlast  // final_res
);
  import scw_pkg::*;

  localparam int CW = $clog2(MAX_WINDOW + 1);
  localparam int AW = $clog2(MAX_WINDOW);
  localparam int VB = VALUE_BITS;

  scw_state_t state_r, state_nxt;
  logic [CW-1:0] fc_r, fc_nxt, bc_r, bc_nxt, best_r, best_nxt;
  logic          found_r, found_nxt, last_r, last_nxt, over_r, over_nxt;
  logic [VB-1:0] x_r, x_nxt, btop_r, btop_nxt, ftop_r, ftop_nxt;

  logic          g_start, g_busy, g_done;
  logic [VB-1:0] g_a, g_b, g_res;
  logic          bv_we, fg_we;
  logic [VB-1:0] bv_rdata, fg_rdata;
  logic [CW:0]   fill;
  logic [CW-1:0] len;

  // Shared GCD unit.
  scw_gcd #(.W(VB)) u_gcd (
    .clk(clk), .rst_n(rst_n), .start(g_start), .a_in(g_a), .b_in(g_b),
    .busy(g_busy), .done(g_done), .result(g_res)
  );

  // Back stack values, read from the top while moving to the front.
  scw_ram #(.DEPTH(MAX_WINDOW), .W(VB)) u_back_vals (
    .clk(clk), .we(bv_we), .waddr(bc_r[AW-1:0]), .wdata(x_r),
    .raddr(AW'(bc_r - CW'(1))), .rdata(bv_rdata)
  );

  // Front stack GCD prefixes, read after each pop.
  scw_ram #(.DEPTH(MAX_WINDOW), .W(VB)) u_front_gcds (
    .clk(clk), .we(fg_we), .waddr(fc_r[AW-1:0]), .wdata(g_res),
    .raddr(AW'(fc_r - CW'(1))), .rdata(fg_rdata)
  );

  assign fill = {1'b0, fc_r} + {1'b0, bc_r};
  assign len  = fc_r + bc_r;

  // State and window registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      fc_r    <= '0;
      bc_r    <= '0;
      best_r  <= '0;
      found_r <= 1'b0;
      btop_r  <= '0;
      ftop_r  <= '0;
    end else begin
      state_r <= state_nxt;
      fc_r    <= fc_nxt;
      bc_r    <= bc_nxt;
      best_r  <= best_nxt;
      found_r <= found_nxt;
      btop_r  <= btop_nxt;
      ftop_r  <= ftop_nxt;
    end
    x_r    <= x_nxt;
    last_r <= last_nxt;
    over_r <= over_nxt;
  end

  // Sequencer: refuse when full, else push, check and pop, move back stack to front when needed; then hold the result.
  always_comb begin
    state_nxt = state_r;
    fc_nxt    = fc_r;
    bc_nxt    = bc_r;
    best_nxt  = best_r;
    found_nxt = found_r;
    btop_nxt  = btop_r;
    ftop_nxt  = ftop_r;
    x_nxt     = x_r;
    last_nxt  = last_r;
    over_nxt  = over_r;
    g_start   = 1'b0;
    g_a       = ftop_r;
    g_b       = btop_r;
    bv_we     = 1'b0;
    fg_we     = 1'b0;
    in_tready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          x_nxt    = in_tdata[VB-1:0];
          last_nxt = in_tlast;
          if (fill >= (CW+1)'(MAX_WINDOW)) begin
            over_nxt  = 1'b1;
            state_nxt = S_OUT;
          end else begin
            over_nxt  = 1'b0;
            g_start   = 1'b1;
            g_a       = btop_r;
            g_b       = in_tdata[VB-1:0];
            state_nxt = S_PUSH;
          end
        end
      end
      S_PUSH: begin
        if (g_done) begin
          bv_we     = 1'b1;
          bc_nxt    = bc_r + CW'(1);
          btop_nxt  = g_res;
          g_start   = 1'b1;
          g_a       = ftop_r;
          g_b       = g_res;
          state_nxt = S_CHK;
        end
      end
      S_CHK: begin
        if (g_done) begin
          if (g_res == VB'(1)) begin
            if (!found_r || len < best_r) begin
              best_nxt = len;
            end
            found_nxt = 1'b1;
            if (fc_r == '0) begin
              state_nxt = S_XRD;
            end else begin
              fc_nxt    = fc_r - CW'(1);
              state_nxt = S_FRD;
            end
          end else begin
            state_nxt = S_OUT;
          end
        end
      end
      S_FRD: begin
        state_nxt = S_FWT;
      end
      S_FWT: begin
        ftop_nxt  = (fc_r == '0) ? '0 : fg_rdata;
        g_start   = 1'b1;
        g_a       = (fc_r == '0) ? '0 : fg_rdata;
        g_b       = btop_r;
        state_nxt = S_CHK;
      end
      S_XRD: begin
        if (bc_r == '0) begin
          btop_nxt  = '0;
          fc_nxt    = fc_r - CW'(1);
          state_nxt = S_FRD;
        end else begin
          bc_nxt    = bc_r - CW'(1);
          state_nxt = S_XWT;
        end
      end
      S_XWT: begin
        g_start   = 1'b1;
        g_a       = ftop_r;
        g_b       = bv_rdata;
        state_nxt = S_XG;
      end
      S_XG: begin
        if (g_done) begin
          fg_we     = 1'b1;
          fc_nxt    = fc_r + CW'(1);
          ftop_nxt  = g_res;
          state_nxt = S_XRD;
        end
      end
      S_OUT: begin
        if (out_tready) begin
          if (last_r) begin
            fc_nxt    = '0;
            bc_nxt    = '0;
            best_nxt  = '0;
            found_nxt = 1'b0;
            btop_nxt  = '0;
            ftop_nxt  = '0;
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Result item.
  assign out_tvalid = (state_r == S_OUT);
  assign out_tdata  = OUT_TDATA_W'(BEST_W'(best_r));
  assign out_tuser  = {over_r, found_r};
  assign out_tlast  = last_r;

  // The window never holds more than its capacity.
  a_fill_max: assert property (@(posedge clk) disable iff (!rst_n)
    fill <= (CW+1)'(MAX_WINDOW))
    else $error("window over capacity");

  // No item is taken while a result waits.
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !out_tvalid)
    else $error("input ready while result pending");

  // Delivering the final result clears the window and the best length.
  a_final_clr: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && out_tlast) |=>
      (fc_r == '0 && bc_r == '0 && best_r == '0 && !found_r))
    else $error("window not cleared after final result");

  // A refused item never starts a GCD.
  a_refuse: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && fill >= (CW+1)'(MAX_WINDOW)) |-> !g_start)
    else $error("refused item pushed");

  // The sequencer only starts the GCD unit while it is free.
  a_gcd_free: assert property (@(posedge clk) disable iff (!rst_n)
    g_start |-> !g_busy)
    else $error("gcd unit started while busy");

endmodule

`default_nettype wire
